// ===== rtl/ctt_pkg.sv =====
// Shared types and constants for the configuration text tokenizer.
// Depends on nothing; the lexer, top level and checker files import it.
package ctt_pkg;

  localparam int CountWidth = 16;
  localparam int OutCountW  = 16;
  localparam int MaxEvents  = 4;
  localparam int EvIdxW     = $clog2(MaxEvents);
  localparam int EvCntW     = $clog2(MaxEvents + 1);

  localparam logic [2:0] EvValue       = 3'd0;
  localparam logic [2:0] EvEnd         = 3'd1;
  localparam logic [2:0] EvUnrec       = 3'd2;
  localparam logic [2:0] EvOpenBracket = 3'd3;
  localparam logic [2:0] EvOpenBrace   = 3'd4;
  localparam logic [2:0] EvOpenQuote   = 3'd5;

  localparam logic [2:0] TkSection  = 3'd0;
  localparam logic [2:0] TkKeyword  = 3'd1;
  localparam logic [2:0] TkVariable = 3'd2;
  localparam logic [2:0] TkList     = 3'd3;
  localparam logic [2:0] TkString   = 3'd4;

  localparam logic [7:0] ChBracketOpen  = 8'h5B;
  localparam logic [7:0] ChBracketClose = 8'h5D;
  localparam logic [7:0] ChBraceOpen    = 8'h7B;
  localparam logic [7:0] ChBraceClose   = 8'h7D;
  localparam logic [7:0] ChDash         = 8'h2D;
  localparam logic [7:0] ChQuote        = 8'h22;
  localparam logic [7:0] ChNewline      = 8'h0A;
  localparam logic [7:0] ChSpace        = 8'h20;

  typedef struct packed {
    logic [2:0]           event_kind;
    logic [2:0]           token_kind;
    logic [7:0]           value_byte;
    logic [OutCountW-1:0] line_number;
    logic [OutCountW-1:0] column_number;
  } ctt_event_t;

  typedef struct packed {
    ctt_event_t [MaxEvents-1:0] events;
    logic [EvCntW-1:0]          count;
  } ctt_batch_t;

  function automatic logic is_ws(input logic [7:0] b);
    return (b == ChSpace) || (b >= 8'h09 && b <= 8'h0D);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_alpha(b) || (b >= 8'h30 && b <= 8'h39);
  endfunction

endpackage

// ===== rtl/ctt_if.sv =====
// Valid/ready channel interfaces for the tokenizer: text bytes in, events out.
// Depends on nothing.
interface ctt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface ctt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [2:0]  token_kind;
  logic [7:0]  value_byte;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_result;

  modport source (output valid, output event_kind, output token_kind, output value_byte,
                  output line_number, output column_number, output last_result,
                  input ready);
  modport sink   (input valid, input event_kind, input token_kind, input value_byte,
                  input line_number, input column_number, input last_result,
                  output ready);
endinterface

// ===== rtl/ctt_lexer.sv =====
// Scan state (mode, line and column counts) and the per-byte event batch.
// Depends on ctt_pkg.
module ctt_lexer #(
  parameter int COUNT_WIDTH = ctt_pkg::CountWidth
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  logic [7:0]         in_byte,
  input  logic               end_of_input,
  output ctt_pkg::ctt_batch_t batch
);
  import ctt_pkg::*;

  typedef enum logic [2:0] {
    ModeIdle     = 3'd0,
    ModeDash     = 3'd1,
    ModeSection  = 3'd2,
    ModeKeyword  = 3'd3,
    ModeVariable = 3'd4,
    ModeList     = 3'd5,
    ModeString   = 3'd6
  } mode_t;

  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  mode_t                  mode_r, mode_nxt;
  logic [COUNT_WIDTH-1:0] line_r, line_nxt;
  logic [COUNT_WIDTH-1:0] col_r, col_nxt;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == '1) ? v : v + CountOne;
  endfunction

  function automatic logic [OutCountW-1:0] to_out(input logic [COUNT_WIDTH-1:0] v);
    logic [COUNT_WIDTH+OutCountW-1:0] t;
    t = {{OutCountW{1'b0}}, v};
    return t[OutCountW-1:0];
  endfunction

  function automatic ctt_event_t make_ev(input logic [2:0] ek, input logic [2:0] tk,
                                         input logic [7:0] vb,
                                         input logic [COUNT_WIDTH-1:0] ln,
                                         input logic [COUNT_WIDTH-1:0] cl);
    ctt_event_t e;
    e.event_kind    = ek;
    e.token_kind    = tk;
    e.value_byte    = vb;
    e.line_number   = to_out(ln);
    e.column_number = to_out(cl);
    return e;
  endfunction

  always_comb begin
    logic [EvCntW-1:0]          n_v;
    ctt_event_t [MaxEvents-1:0] ev_v;
    logic                       redo;
    mode_t                      m_v;
    logic [COUNT_WIDTH-1:0]     ln_v;
    logic [COUNT_WIDTH-1:0]     cl_v;

    n_v  = '0;
    ev_v = '0;
    redo = 1'b0;
    m_v  = mode_r;
    ln_v = line_r;
    cl_v = col_r;

    unique case (mode_r)
      ModeDash: begin
        m_v = ModeIdle;
        if (in_byte == ChSpace) begin
          cl_v = sat_inc(sat_inc(cl_v));
          m_v  = ModeKeyword;
        end else begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvUnrec, TkSection, 8'h00, ln_v, cl_v);
          n_v  = n_v + 1'b1;
          redo = 1'b1;
        end
      end
      ModeSection, ModeList: begin
        cl_v = sat_inc(cl_v);
        ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, (mode_r == ModeList) ? TkList : TkSection,
                                        in_byte, ln_v, cl_v);
        n_v = n_v + 1'b1;
        if ((mode_r == ModeSection && in_byte == ChBracketClose) ||
            (mode_r == ModeList && in_byte == ChBraceClose)) begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, (mode_r == ModeList) ? TkList : TkSection,
                                          8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
          m_v = ModeIdle;
        end
      end
      ModeKeyword: begin
        if (is_ws(in_byte)) begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkKeyword, 8'h00, ln_v, cl_v);
          n_v  = n_v + 1'b1;
          m_v  = ModeIdle;
          redo = 1'b1;
        end else begin
          cl_v = sat_inc(cl_v);
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, TkKeyword, in_byte, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
      end
      ModeVariable: begin
        if (is_alnum(in_byte)) begin
          cl_v = sat_inc(cl_v);
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, TkVariable, in_byte, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end else begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkVariable, 8'h00, ln_v, cl_v);
          n_v  = n_v + 1'b1;
          m_v  = ModeIdle;
          redo = 1'b1;
        end
      end
      ModeString: begin
        cl_v = sat_inc(cl_v);
        if (in_byte == ChQuote) begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkString, 8'h00, ln_v, cl_v);
          m_v = ModeIdle;
        end else begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, TkString, in_byte, ln_v, cl_v);
        end
        n_v = n_v + 1'b1;
      end
      default: begin
        m_v  = ModeIdle;
        redo = 1'b1;
      end
    endcase

    if (redo) begin
      if (is_ws(in_byte)) begin
        if (in_byte == ChNewline) begin
          ln_v = sat_inc(ln_v);
          cl_v = CountOne;
        end else begin
          cl_v = sat_inc(cl_v);
        end
      end else if (in_byte == ChBracketOpen) begin
        cl_v = sat_inc(cl_v);
        ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, TkSection, in_byte, ln_v, cl_v);
        n_v = n_v + 1'b1;
        m_v = ModeSection;
      end else if (in_byte == ChDash) begin
        m_v = ModeDash;
      end else if (is_alpha(in_byte)) begin
        cl_v = sat_inc(cl_v);
        ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, TkVariable, in_byte, ln_v, cl_v);
        n_v = n_v + 1'b1;
        m_v = ModeVariable;
      end else if (in_byte == ChBraceOpen) begin
        cl_v = sat_inc(cl_v);
        ev_v[n_v[EvIdxW-1:0]] = make_ev(EvValue, TkList, in_byte, ln_v, cl_v);
        n_v = n_v + 1'b1;
        m_v = ModeList;
      end else if (in_byte == ChQuote) begin
        cl_v = sat_inc(cl_v);
        m_v  = ModeString;
      end else begin
        ev_v[n_v[EvIdxW-1:0]] = make_ev(EvUnrec, TkSection, 8'h00, ln_v, cl_v);
        n_v = n_v + 1'b1;
      end
    end

    if (end_of_input) begin
      case (m_v)
        ModeDash: begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvUnrec, TkSection, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
        ModeSection: begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvOpenBracket, TkSection, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkSection, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
        ModeKeyword: begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkKeyword, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
        ModeVariable: begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkVariable, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
        ModeList: begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvOpenBrace, TkList, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkList, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
        ModeString: begin
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvOpenQuote, TkString, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
          ev_v[n_v[EvIdxW-1:0]] = make_ev(EvEnd, TkString, 8'h00, ln_v, cl_v);
          n_v = n_v + 1'b1;
        end
        default: begin
        end
      endcase
      m_v  = ModeIdle;
      ln_v = CountOne;
      cl_v = CountOne;
    end

    batch.events = ev_v;
    batch.count  = n_v;
    mode_nxt     = m_v;
    line_nxt     = ln_v;
    col_nxt      = cl_v;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeIdle;
      line_r <= CountOne;
      col_r  <= CountOne;
    end else if (take) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

endmodule

// ===== rtl/config_text_tokenizer.sv =====
// Configuration text tokenizer top level: scan state plus the result buffer.
// Depends on ctt_pkg, ctt_in_if, ctt_out_if and ctt_lexer.
//
// Usage: text bytes enter on in_ch, one per transaction, with end_of_input
// set on the final byte of a text. Each byte yields zero to four events on
// out_ch: value bytes, token ends, unrecognized bytes and unterminated
// lexemes, each stamped with the line and column count (low 16 bits).
// last_result marks the final event caused by a byte.
// The first event of a byte is presented the cycle after the byte is taken.
// One byte per cycle is taken while each byte yields at most one event and the
// receiver is ready; a byte with more than one event holds the input until its
// last event is leaving, since the output register drains one event per cycle
// while the receiver is ready. Bytes that yield no event pass at one per cycle.
// A stalled receiver holds the buffered events; a new byte is taken in the
// same cycle as the last buffered event leaves.
// Reset (rst_n low at a clock edge) returns to between tokens, sets both
// counts to one and empties the buffer. After a byte marked end_of_input,
// the next text likewise starts between tokens with both counts at one.
module config_text_tokenizer #(
  parameter int COUNT_WIDTH = ctt_pkg::CountWidth
) (
  input logic      clk,
  input logic      rst_n,
  ctt_in_if.sink   in_ch,
  ctt_out_if.source out_ch
);
  import ctt_pkg::*;

  ctt_batch_t                 batch;
  ctt_event_t [MaxEvents-1:0] ev_r;
  logic [EvCntW-1:0]          cnt_r;
  logic                       in_take;
  logic                       out_take;

  assign out_take    = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (cnt_r == '0) || ((cnt_r == EvCntW'(1)) && out_ch.ready);
  assign in_take     = in_ch.valid && in_ch.ready;

  ctt_lexer #(.COUNT_WIDTH(COUNT_WIDTH)) u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .take         (in_take),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .batch        (batch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_take) begin
      cnt_r <= batch.count;
    end else if (out_take) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ev_r <= batch.events;
    end else if (out_take) begin
      for (int i = 0; i < MaxEvents - 1; i++) begin
        ev_r[i] <= ev_r[i+1];
      end
    end
  end

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.event_kind    = ev_r[0].event_kind;
  assign out_ch.token_kind    = ev_r[0].token_kind;
  assign out_ch.value_byte    = ev_r[0].value_byte;
  assign out_ch.line_number   = ev_r[0].line_number;
  assign out_ch.column_number = ev_r[0].column_number;
  assign out_ch.last_result   = (cnt_r == EvCntW'(1));

endmodule

// ===== rtl/ctt_checker.sv =====
// Port-level checks on the tokenizer result channel, bound to the top level.
// Depends on ctt_pkg and config_text_tokenizer.
module ctt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  event_kind,
  input logic [2:0]  token_kind,
  input logic [7:0]  value_byte,
  input logic        last_result
);
  import ctt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last_result |=> out_valid)
    else $error("missing follow-up result of the same byte");

  a_open_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (event_kind == EvOpenBracket || event_kind == EvOpenBrace ||
                  event_kind == EvOpenQuote) |-> !last_result)
    else $error("unterminated lexeme not followed by token end");

  a_unrec_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && event_kind == EvUnrec |-> token_kind == TkSection && value_byte == 8'h00)
    else $error("unrecognized event carries token data");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .event_kind  (out_ch.event_kind),
  .token_kind  (out_ch.token_kind),
  .value_byte  (out_ch.value_byte),
  .last_result (out_ch.last_result)
);
